// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sscoll_pkg.sv =====
// Shared constants of the swept sphere collision unit.
package sscoll_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  // Multiplier digit taken per pipeline stage of the wide multipliers.
  localparam int MUL_DIGIT   = 16;

endpackage

// ===== src/sscoll_mul.sv =====
// Pipelined unsigned wide multiplier, one digit of b per stage.
module sscoll_mul #(
  parameter int WA  = 66,
  parameter int WB  = 66,
  parameter int DIG = sscoll_pkg::MUL_DIGIT
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int ND  = (WB + DIG - 1) / DIG;
  localparam int BPW = ND * DIG;
  localparam int AW  = WA + BPW;

  logic [BPW-1:0] b_ext;
  logic [WA-1:0]  a_q   [ND];
  logic [BPW-1:0] b_q   [ND];
  logic [AW-1:0]  acc   [ND];

  assign b_ext = BPW'(b);

  for (genvar k = 0; k < ND; k++) begin : g_stage
    logic [WA-1:0]     a_src;
    logic [BPW-1:0]    b_src;
    logic [AW-1:0]     acc_src;
    logic [WA+DIG-1:0] part;

    if (k == 0) begin : g_first
      assign a_src   = a;
      assign b_src   = b_ext;
      assign acc_src = '0;
    end else begin : g_next
      assign a_src   = a_q[k-1];
      assign b_src   = b_q[k-1];
      assign acc_src = acc[k-1];
    end

    assign part = (WA+DIG)'(a_src) * (WA+DIG)'(b_src[DIG*k +: DIG]);

    always_ff @(posedge clk) begin
      if (en) begin
        a_q[k] <= a_src;
        b_q[k] <= b_src;
        acc[k] <= acc_src + (AW'(part) << (DIG * k));
      end
    end
  end

  assign p = acc[ND-1][WA+WB-1:0];

endmodule

// ===== src/swept_sphere_collision_test_unit.sv =====
// Swept sphere against sphere collision test, pipelined top level.
//
// Usage:
//   Input channel s_axis_*: one item per sphere pair (center offset, both
//   movement vectors, both radii). Output channel m_axis_*: one result item
//   per input item, in order. tuser carries the hit flag; tdata carries the
//   fraction of the step before contact and both movements scaled by it.
//   A miss returns hit, fraction and all scaled vectors as zero.
// Throughput: one item per cycle, sustained, while the receiver takes items.
// Depth: stages A to D, then ND = ceil((2*COORD_WIDTH+2)/16) wide-multiplier
//   stages, stages E and F, RW = 2*COORD_WIDTH+2+FRAC_BITS square root stages
//   (one root bit per stage), stages G1 and G2, the divide stages and the
//   output stage. The square root of the closest-approach term sets most of
//   that depth, the restoring divide for the fraction (one quotient bit per
//   stage) the rest.
// Reset: rst clears all pipeline valid bits; items in flight are dropped.
// Stall: when the output holds an item that is not taken, the whole
//   pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
//   An empty output slot lets the pipeline move even while tready is low.
`include "assert_macros.svh"

module swept_sphere_collision_test_unit #(
  parameter int COORD_WIDTH = sscoll_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = sscoll_pkg::FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // center_dx, center_dy, center_dz, move_a_x/y/z, move_b_x/y/z,
  // radius_a, radius_b (from bit 0 up), zero padded to bytes
  input  logic [((11*COORD_WIDTH-2+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // fraction, scaled_a_x/y/z, scaled_b_x/y/z (from bit 0 up), zero padded
  output logic [((FRAC_BITS+1+6*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // hit
  output logic m_axis_tuser
);

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int MW   = CW + 1;            // relative motion component
  localparam int XW   = 2 * CW + 2;        // dot products and their magnitudes
  localparam int QW   = 2 * XW + 2;        // closest approach term, signed
  localparam int SW   = 2 * XW + 2 * FB;   // radicand
  localparam int RW   = XW + FB;           // root
  localparam int RMW  = RW + 2;            // root remainder
  localparam int DW2  = XW + FB;           // division numerator
  localparam int DIG  = sscoll_pkg::MUL_DIGIT;
  localparam int ND   = (XW + DIG - 1) / DIG;
  localparam int NST  = 4 + ND + 2 + RW + 2 + (FB + 1) + 1;
  localparam logic [FB:0] FRAC_ONE = (FB+1)'(1) << FB;

  typedef struct packed {
    logic                  miss;
    logic                  eneg;  // sign of R^2 - C2
    logic                  dnn;   // P - M2 not negative
    logic [XW-1:0]         m2;
    logic [XW-1:0]         p;
    logic [2:0][CW-1:0]    ma;
    logic [2:0][CW-1:0]    mb;
  } side_t;

  logic en;
  logic [NST-1:0] vld;

  assign en            = !vld[NST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  // ---------------- stage A: unpack, relative motion, radius sum
  logic [2:0][CW-1:0] in_c, in_ma, in_mb;
  logic [CW-2:0]      in_ra, in_rb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_c[i]  = s_axis_tdata[CW*i +: CW];
      in_ma[i] = s_axis_tdata[CW*(3+i) +: CW];
      in_mb[i] = s_axis_tdata[CW*(6+i) +: CW];
    end
    in_ra = s_axis_tdata[9*CW +: CW-1];
    in_rb = s_axis_tdata[10*CW-1 +: CW-1];
  end

  logic [2:0][MW-1:0] a_m;
  logic [2:0][CW-1:0] a_c, a_ma, a_mb;
  logic [CW-1:0]      a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_m[i] <= MW'($signed(in_ma[i])) - MW'($signed(in_mb[i]));
      end
      a_c  <= in_c;
      a_ma <= in_ma;
      a_mb <= in_mb;
      a_r  <= CW'(in_ra) + CW'(in_rb);
    end
  end

  // ---------------- stage B: component products
  logic signed [2*MW-1:0] mm_t [3];
  logic signed [2*CW-1:0] cc_t [3];
  logic signed [2*CW:0]   mc_t [3];
  logic [2*CW-1:0]        r2_t;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mm_t[i] = $signed(a_m[i]) * $signed(a_m[i]);
      cc_t[i] = $signed(a_c[i]) * $signed(a_c[i]);
      mc_t[i] = $signed(a_m[i]) * $signed(a_c[i]);
    end
    r2_t = (2*CW)'(a_r) * (2*CW)'(a_r);
  end

  logic [2:0][2*CW:0]   b_mm;
  logic [2:0][2*CW-2:0] b_cc;
  logic [2:0][2*CW:0]   b_mc;
  logic [2*CW-1:0]      b_r2;
  logic [2:0][CW-1:0]   b_ma, b_mb;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b_mm[i] <= mm_t[i][2*CW:0];
        b_cc[i] <= cc_t[i][2*CW-2:0];
        b_mc[i] <= mc_t[i];
      end
      b_r2 <= r2_t;
      b_ma <= a_ma;
      b_mb <= a_mb;
    end
  end

  // ---------------- stage C: dot products M2, C2, P
  logic [XW-1:0]      c_m2, c_p;
  logic [2*CW-1:0]    c_c2, c_r2;
  logic [2:0][CW-1:0] c_ma, c_mb;

  always_ff @(posedge clk) begin
    if (en) begin
      c_m2 <= XW'(b_mm[0]) + XW'(b_mm[1]) + XW'(b_mm[2]);
      c_c2 <= (2*CW)'(b_cc[0]) + (2*CW)'(b_cc[1]) + (2*CW)'(b_cc[2]);
      c_p  <= XW'($signed(b_mc[0])) + XW'($signed(b_mc[1])) + XW'($signed(b_mc[2]));
      c_r2 <= b_r2;
      c_ma <= b_ma;
      c_mb <= b_mb;
    end
  end

  // ---------------- stage D: R^2 - C2, P - M2, early miss
  logic signed [XW-1:0] e_t;
  logic signed [XW:0]   diff_t;

  assign e_t    = $signed({2'b00, c_r2}) - $signed({2'b00, c_c2});
  assign diff_t = $signed({c_p[XW-1], c_p}) - $signed({1'b0, c_m2});

  logic [XW-1:0] d_emag, d_dmag;
  side_t         d_sd;

  always_ff @(posedge clk) begin
    if (en) begin
      d_emag      <= e_t[XW-1] ? XW'(-e_t) : XW'(e_t);
      d_dmag      <= diff_t[XW-1:0];
      d_sd.miss   <= (c_m2 == '0) || c_p[XW-1] || (c_p == '0);
      d_sd.eneg   <= e_t[XW-1];
      d_sd.dnn    <= !diff_t[XW];
      d_sd.m2     <= c_m2;
      d_sd.p      <= c_p;
      d_sd.ma     <= c_ma;
      d_sd.mb     <= c_mb;
    end
  end

  // ---------------- wide products P^2, |R^2-C2|*M2, (P-M2)^2
  logic [2*XW-1:0] mul_pp, mul_em, mul_dd;

  sscoll_mul #(.WA(XW), .WB(XW), .DIG(DIG)) u_mul_pp (
    .clk(clk), .en(en), .a(d_sd.p), .b(d_sd.p), .p(mul_pp)
  );
  sscoll_mul #(.WA(XW), .WB(XW), .DIG(DIG)) u_mul_em (
    .clk(clk), .en(en), .a(d_emag), .b(d_sd.m2), .p(mul_em)
  );
  sscoll_mul #(.WA(XW), .WB(XW), .DIG(DIG)) u_mul_dd (
    .clk(clk), .en(en), .a(d_dmag), .b(d_dmag), .p(mul_dd)
  );

  side_t m_sd [ND];

  always_ff @(posedge clk) begin
    if (en) begin
      m_sd[0] <= d_sd;
      for (int k = 1; k < ND; k++) begin
        m_sd[k] <= m_sd[k-1];
      end
    end
  end

  // ---------------- stage E: Q = P^2 + (R^2 - C2)*M2
  logic signed [QW-1:0] emx_t;
  logic signed [QW-1:0] e_q;
  logic [2*XW-1:0]      e_pp, e_dd;
  side_t                e_sd;

  assign emx_t = m_sd[ND-1].eneg ? -$signed(QW'(mul_em)) : $signed(QW'(mul_em));

  always_ff @(posedge clk) begin
    if (en) begin
      e_q  <= $signed(QW'(mul_pp)) + emx_t;
      e_pp <= mul_pp;
      e_dd <= mul_dd;
      e_sd <= m_sd[ND-1];
    end
  end

  // ---------------- stage F: remaining miss tests, radicand Q << 2*FB
  logic  f_miss_t;
  logic  [SW-1:0] f_rad;
  side_t f_sd_t;
  side_t f_sd;

  assign f_miss_t = e_q[QW-1] || (e_q == '0)
                 || ($signed(QW'(e_pp)) < e_q)
                 || (e_sd.dnn && ($signed(QW'(e_dd)) > e_q));

  always_comb begin
    f_sd_t      = e_sd;
    f_sd_t.miss = e_sd.miss || f_miss_t;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_rad       <= SW'(e_q[2*XW-1:0]) << (2 * FB);
      f_sd        <= f_sd_t;
    end
  end

  // ---------------- square root, one root bit per stage
  logic [SW-1:0]  sq_rad  [RW];
  logic [RMW-1:0] sq_rem  [RW];
  logic [RW-1:0]  sq_root [RW];
  side_t          sq_sd   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [SW-1:0]  rad_in;
    logic [RMW-1:0] rem_in, cat, trial;
    logic [RW-1:0]  root_in;
    side_t          sd_in;
    logic           ge;

    if (k == 0) begin : g_first
      assign rad_in  = f_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sd_in   = f_sd;
    end else begin : g_next
      assign rad_in  = sq_rad[k-1];
      assign rem_in  = sq_rem[k-1];
      assign root_in = sq_root[k-1];
      assign sd_in   = sq_sd[k-1];
    end

    assign cat   = {rem_in[RMW-3:0], rad_in[SW-1:SW-2]};
    assign trial = {root_in, 2'b01};
    assign ge    = cat >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad[k]  <= rad_in << 2;
        sq_rem[k]  <= ge ? cat - trial : cat;
        sq_root[k] <= {root_in[RW-2:0], ge};
        sq_sd[k]   <= sd_in;
      end
    end
  end

  // ---------------- G1: round root up, G2: numerator (P << FB) - root
  logic [RW:0]    g1_root;
  side_t          g1_sd;
  logic [DW2:0]   g2_t;
  logic [DW2-1:0] g2_num;
  side_t          g2_sd;

  assign g2_t = ((DW2+1)'(g1_sd.p) << FB) - (DW2+1)'(g1_root);

  always_ff @(posedge clk) begin
    if (en) begin
      g1_root <= (RW+1)'(sq_root[RW-1]) + (RW+1)'(sq_rem[RW-1] != '0);
      g1_sd   <= sq_sd[RW-1];
      g2_num  <= g2_t[DW2] ? '0 : g2_t[DW2-1:0];
      g2_sd   <= g1_sd;
    end
  end

  // ---------------- restoring divide by M2, quotient MSB first
  logic [DW2-1:0] dv_num  [FB+1];
  logic [FB:0]    dv_frac [FB+1];
  side_t          dv_sd   [FB+1];

  for (genvar k = 0; k <= FB; k++) begin : g_div
    logic [DW2-1:0] num_in, dvs;
    logic [FB:0]    frac_in;
    side_t          sd_in;
    logic           ge;

    if (k == 0) begin : g_first
      assign num_in  = g2_num;
      assign frac_in = '0;
      assign sd_in   = g2_sd;
    end else begin : g_next
      assign num_in  = dv_num[k-1];
      assign frac_in = dv_frac[k-1];
      assign sd_in   = dv_sd[k-1];
    end

    assign dvs = DW2'(sd_in.m2) << (FB - k);
    assign ge  = num_in >= dvs;

    always_ff @(posedge clk) begin
      if (en) begin
        dv_num[k]  <= ge ? num_in - dvs : num_in;
        dv_frac[k] <= frac_in | ((FB+1)'(ge) << (FB - k));
        dv_sd[k]   <= sd_in;
      end
    end
  end

  // ---------------- output stage: clamp, scale movements, zero on miss
  logic [FB:0]                 fc_t;
  logic signed [CW+FB+1:0]     pa_t [3];
  logic signed [CW+FB+1:0]     pb_t [3];
  side_t                       o_in;

  assign o_in = dv_sd[FB];
  assign fc_t = (dv_frac[FB] > FRAC_ONE) ? FRAC_ONE : dv_frac[FB];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_t[i] = $signed(o_in.ma[i]) * $signed({1'b0, fc_t});
      pb_t[i] = $signed(o_in.mb[i]) * $signed({1'b0, fc_t});
    end
  end

  logic               o_hit;
  logic [FB:0]        o_frac;
  logic [2:0][CW-1:0] o_sa, o_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit  <= !o_in.miss;
      o_frac <= o_in.miss ? '0 : fc_t;
      for (int i = 0; i < 3; i++) begin
        o_sa[i] <= o_in.miss ? '0 : pa_t[i][FB+CW-1:FB];
        o_sb[i] <= o_in.miss ? '0 : pb_t[i][FB+CW-1:FB];
      end
    end
  end

  assign m_axis_tuser = o_hit;
  assign m_axis_tdata = $bits(m_axis_tdata)'({o_sb, o_sa, o_frac});

  // ---------------- checks
  `ASSERT_CLK(a_miss_zero, clk, rst, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0, "miss result not zero")
  `ASSERT_CLK(a_frac_range, clk, rst, m_axis_tvalid |-> m_axis_tdata[FB:0] <= FRAC_ONE, "fraction above one step")
  `ASSERT_CLK_NR(a_reset_empty, clk, rst |=> !m_axis_tvalid, "output valid right after reset")

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for the swept sphere collision unit with randomized stream handshakes.
`timescale 1ns / 1ps

module tb;

  localparam int CW      = sscoll_pkg::COORD_WIDTH;
  localparam int FB      = sscoll_pkg::FRAC_BITS;
  localparam int IN_W    = ((11*CW-2+7)/8)*8;
  localparam int OUT_W   = ((FB+1+6*CW+7)/8)*8;
  localparam int LATENCY = 113;
  localparam int LIMIT   = 400000;
  localparam logic [CW-1:0] ONE = 1 << FB;   // 1.0 in Q16.16

  // 320 bits holds every intermediate product with room to spare
  typedef logic signed [319:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] c[3];    // second center minus first center
    logic signed [CW-1:0] ma[3];   // first sphere movement
    logic signed [CW-1:0] mb[3];   // second sphere movement
    logic [CW-2:0]        ra, rb;  // radii
  } pair_t;

  typedef struct {
    logic                 hit;
    logic [FB:0]          frac;
    logic signed [CW-1:0] sa[3];
    logic signed [CW-1:0] sb[3];
  } contact_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;

  contact_t pending_contacts[$];
  int       errs = 0;
  int       cycles = 0;
  bit       idle_on = 1'b1;

  swept_sphere_collision_test_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Smallest r with r*r >= x. Roots stay below 2^90 at these widths.
  function automatic wide_t root_ceil(wide_t x);
    wide_t r, t;
    r = '0;
    for (int i = 100; i >= 0; i--) begin
      t = r | (wide_t'(1) << i);
      if (t * t <= x) r = t;
    end
    if (r * r != x) r = r + 1;
    return r;
  endfunction

  // Exact swept sphere test on wide integers.
  // m = move_a - move_b, P = m.C, M2 = |m|^2, Q = P^2 + (R^2 - |C|^2) * M2,
  // fraction = (P - sqrt(Q)) / M2 in Q16.
  function automatic contact_t sweep_contact(pair_t pr);
    contact_t res;
    wide_t    mi, ci, m2, c2, p, rs, pp, q, diff, num, dv, sc;
    logic [FB:0] fr;
    res.hit = 1'b0;
    res.frac = '0;
    for (int i = 0; i < 3; i++) begin
      res.sa[i] = '0;
      res.sb[i] = '0;
    end
    m2 = '0; c2 = '0; p = '0;
    for (int i = 0; i < 3; i++) begin
      mi = wide_t'(pr.ma[i]) - wide_t'(pr.mb[i]);
      ci = wide_t'(pr.c[i]);
      m2 += mi * mi;
      c2 += ci * ci;
      p  += mi * ci;
    end
    if (m2 == 0) return res;          // no relative motion
    if (p <= 0) return res;           // moving apart or sideways
    rs = wide_t'(pr.ra) + wide_t'(pr.rb);
    pp = p * p;
    q = pp + (rs * rs - c2) * m2;
    if (q <= 0) return res;           // closest approach never touches
    if (pp < q) return res;           // already overlapping
    diff = p - m2;
    if (diff >= 0 && diff * diff > q) return res;  // contact after the step
    num = (p <<< FB) - root_ceil(q <<< (2*FB));
    if (num < 0) num = '0;
    fr = '0;
    for (int i = FB; i >= 0; i--) begin
      dv = m2 <<< i;
      if (dv <= num) begin
        num -= dv;
        fr[i] = 1'b1;
      end
    end
    if (fr > ONE) fr = ONE[FB:0];
    res.hit = 1'b1;
    res.frac = fr;
    for (int i = 0; i < 3; i++) begin
      sc = (wide_t'(pr.ma[i]) * wide_t'(fr)) >>> FB;
      res.sa[i] = sc[CW-1:0];
      sc = (wide_t'(pr.mb[i]) * wide_t'(fr)) >>> FB;
      res.sb[i] = sc[CW-1:0];
    end
    return res;
  endfunction

  // Drives one pair and waits for the accept edge. Valid stays high into the
  // next call unless that call idles first.
  task automatic send_pair(pair_t pr);
    logic [IN_W-1:0] d;
    int gap;
    d = '0;
    for (int i = 0; i < 3; i++) begin
      d[CW*i +: CW]     = pr.c[i];
      d[CW*(3+i) +: CW] = pr.ma[i];
      d[CW*(6+i) +: CW] = pr.mb[i];
    end
    d[9*CW +: CW-1]      = pr.ra;
    d[10*CW-1 +: CW-1]   = pr.rb;
    gap = (idle_on && $urandom_range(0, 99) < 20) ? $urandom_range(1, 2) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_contacts.push_back(sweep_contact(pr));
  endtask

  // Receiver stalls and result checking against the oldest prediction.
  always @(posedge clk) begin
    contact_t got, want;
    if (!rst) begin
      m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 20);
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit  = m_axis_tuser;
        got.frac = m_axis_tdata[FB:0];
        for (int i = 0; i < 3; i++) begin
          got.sa[i] = m_axis_tdata[FB+1+CW*i +: CW];
          got.sb[i] = m_axis_tdata[FB+1+CW*(3+i) +: CW];
        end
        if (pending_contacts.size() == 0) begin
          $error("result item with nothing expected");
          errs++;
        end else begin
          want = pending_contacts.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            errs++;
          end
          if (got.frac !== want.frac) begin
            $error("fraction: expected %0d, got %0d", want.frac, got.frac);
            errs++;
          end
          for (int i = 0; i < 3; i++) begin
            if (got.sa[i] !== want.sa[i]) begin
              $error("scaled_a[%0d]: expected %0d, got %0d", i, want.sa[i], got.sa[i]);
              errs++;
            end
            if (got.sb[i] !== want.sb[i]) begin
              $error("scaled_b[%0d]: expected %0d, got %0d", i, want.sb[i], got.sb[i]);
              errs++;
            end
          end
        end
      end
    end
  end

  // Pair built from whole units along the axes (value times 1.0).
  function automatic pair_t unit_pair(int cx, int cy, int ax, int ay, int bx,
                                      int ra, int rb);
    pair_t pr;
    pr.c[0] = cx * ONE;  pr.c[1] = cy * ONE;  pr.c[2] = '0;
    pr.ma[0] = ax * ONE; pr.ma[1] = ay * ONE; pr.ma[2] = '0;
    pr.mb[0] = bx * ONE; pr.mb[1] = '0;       pr.mb[2] = '0;
    pr.ra = (CW-1)'(ra * ONE);
    pr.rb = (CW-1)'(rb * ONE);
    return pr;
  endfunction

  function automatic int rnd_span(int span);
    return int'($urandom_range(0, 2*span)) - span;
  endfunction

  // Mostly approaching pairs so that hits and every miss branch occur.
  function automatic pair_t rnd_approach();
    pair_t pr;
    int k, m, span;
    span = ($urandom_range(0, 9) == 0) ? (1 << 26) : (1 << 20);
    k = $urandom_range(1, 24);
    for (int i = 0; i < 3; i++) begin
      pr.c[i]  = rnd_span(span);
      m        = (pr.c[i] / 8) * k + rnd_span(span >> 4);
      pr.ma[i] = rnd_span(span);
      pr.mb[i] = pr.ma[i] - m;
    end
    pr.ra = (CW-1)'($urandom_range(0, span >> 1));
    pr.rb = (CW-1)'($urandom_range(0, span >> 1));
    return pr;
  endfunction

  function automatic pair_t rnd_raw();
    pair_t pr;
    for (int i = 0; i < 3; i++) begin
      pr.c[i]  = $urandom();
      pr.ma[i] = $urandom();
      pr.mb[i] = $urandom();
    end
    pr.ra = (CW-1)'($urandom());
    pr.rb = (CW-1)'($urandom());
    return pr;
  endfunction

  // Hand-built cases covering every branch of the test plus the range ends.
  task automatic test_directed();
    pair_t pr;
    send_pair(unit_pair(10, 0, 3, 0, 3, 1, 1));   // equal movements: no relative motion
    send_pair(unit_pair(10, 0, 0, 8, 0, 1, 1));   // sideways motion, not approaching
    send_pair(unit_pair(10, 0, -8, 0, 0, 1, 1));  // moving apart
    send_pair(unit_pair(10, 5, 8, 0, 0, 1, 1));   // passes by too far
    send_pair(unit_pair(1, 0, 1, 0, 0, 1, 1));    // already overlapping
    send_pair(unit_pair(10, 0, 4, 0, 0, 1, 1));   // contact after the step
    send_pair(unit_pair(2, 0, 1, 0, 0, 1, 1));    // touching at the start
    send_pair(unit_pair(10, 0, 8, 0, 0, 1, 1));   // touching at the end
    send_pair(unit_pair(10, 0, 5, 0, -5, 1, 1));  // full hit with both moving
    send_pair(unit_pair(10, 3, 9, 1, -3, 2, 1));  // glancing hit
    send_pair(unit_pair(-20, 7, -30, 5, 0, 3, 4));
    for (int v = 0; v < 4; v++) begin
      // range ends of every field
      for (int i = 0; i < 3; i++) begin
        pr.c[i]  = (v[0]) ? 32'sh7fffffff : 32'sh80000000;
        pr.ma[i] = (v[1]) ? 32'sh80000000 : 32'sh7fffffff;
        pr.mb[i] = (v == 3) ? 32'sh80000000 : 32'sh7fffffff;
      end
      pr.ra = (v[0]) ? '1 : '0;
      pr.rb = (v[1]) ? '1 : '0;
      send_pair(pr);
    end
    pr = unit_pair(30000, 0, 32767, 0, -32768, 0, 0);
    pr.ra = '1;
    pr.rb = '1;
    send_pair(pr);                                 // huge radii, extreme motion
  endtask

  task automatic test_random_mix(int n);
    for (int j = 0; j < n; j++)
      send_pair(($urandom_range(0, 99) < 70) ? rnd_approach() : rnd_raw());
  endtask

  // Back-to-back on both sides with no idling at all.
  task automatic test_full_rate(int n);
    idle_on = 1'b0;
    test_random_mix(n);
    idle_on = 1'b1;
  endtask

  // Sender holds off until the pipeline has drained completely.
  task automatic test_drain_pause();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_contacts.size() != 0) @(posedge clk);
    test_random_mix(20);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix(150);
    test_full_rate(120);
    test_drain_pause();
    test_random_mix(160);
    s_axis_tvalid <= 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/sscoll_pkg.sv
src/sscoll_mul.sv
src/swept_sphere_collision_test_unit.sv
sim/tb.sv
